@@ hdl/rdsm_pkg.sv @@
// shared constants, widths and types for the radial density stencil mask
package rdsm_pkg;

  localparam int COORD_BITS = 12;
  localparam int POS_W      = COORD_BITS + 2;
  localparam int CEN_W      = 16;
  localparam int RAD_W      = 16;
  localparam int DIFF_W     = ((POS_W > CEN_W - 1) ? POS_W : CEN_W - 1) + 2;
  localparam int MAG_W      = DIFF_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int RSQ_W      = 2 * RAD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_R  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_R  = 3'd5;

  typedef struct packed {
    logic signed [CEN_W-1:0] left_cx;
    logic signed [CEN_W-1:0] left_cy;
    logic signed [CEN_W-1:0] right_cx;
    logic signed [CEN_W-1:0] right_cy;
    logic [RSQ_W-1:0]        outer_sq;
    logic [RSQ_W-1:0]        inner_sq;
  } cfg_t;

endpackage

@@ hdl/rdsm_cfg_regs.sv @@
// configuration registers with precomputed squared radii
module rdsm_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output rdsm_pkg::cfg_t                     cfg_o
);

  logic signed [rdsm_pkg::CEN_W-1:0] left_cx_q, left_cy_q, right_cx_q, right_cy_q;
  logic [rdsm_pkg::RAD_W-1:0]        outer_q, inner_q;
  logic [rdsm_pkg::RSQ_W-1:0]        outer_sq_q, inner_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cx_q  <= '0;
      left_cy_q  <= '0;
      right_cx_q <= '0;
      right_cy_q <= '0;
      outer_q    <= '0;
      inner_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rdsm_pkg::CFG_LEFT_CX:  left_cx_q  <= signed'(cfg_wdata_i);
        rdsm_pkg::CFG_LEFT_CY:  left_cy_q  <= signed'(cfg_wdata_i);
        rdsm_pkg::CFG_RIGHT_CX: right_cx_q <= signed'(cfg_wdata_i);
        rdsm_pkg::CFG_RIGHT_CY: right_cy_q <= signed'(cfg_wdata_i);
        rdsm_pkg::CFG_OUTER_R:  outer_q    <= cfg_wdata_i;
        rdsm_pkg::CFG_INNER_R:  inner_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // squared radii, registered from the radius registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_sq_q <= '0;
      inner_sq_q <= '0;
    end else begin
      outer_sq_q <= outer_q * outer_q;
      inner_sq_q <= inner_q * inner_q;
    end
  end

  assign cfg_o.left_cx  = left_cx_q;
  assign cfg_o.left_cy  = left_cy_q;
  assign cfg_o.right_cx = right_cx_q;
  assign cfg_o.right_cy = right_cy_q;
  assign cfg_o.outer_sq = outer_sq_q;
  assign cfg_o.inner_sq = inner_sq_q;

endmodule

@@ hdl/rdsm_eye_pipe.sv @@
// three stage pipeline forming the squared axis offsets to one eye centre
module rdsm_eye_pipe (
  input  logic                                  clk_i,
  input  logic [rdsm_pkg::COORD_BITS-1:0]       qx_i,
  input  logic [rdsm_pkg::COORD_BITS-1:0]       qy_i,
  input  logic signed [rdsm_pkg::CEN_W-1:0]     cx_i,
  input  logic signed [rdsm_pkg::CEN_W-1:0]     cy_i,
  output logic [rdsm_pkg::SQ_W-1:0]             sq_x_o,
  output logic [rdsm_pkg::SQ_W-1:0]             sq_y_o
);

  logic signed [rdsm_pkg::DIFF_W-1:0] pos_x, pos_y, cen_x, cen_y;
  logic signed [rdsm_pkg::DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [rdsm_pkg::MAG_W-1:0]         mx_d, my_d, mx_q, my_q;
  logic [rdsm_pkg::SQ_W-1:0]          sx_d, sy_d, sx_q, sy_q;

  // corner in quarter pixels
  assign pos_x = signed'(rdsm_pkg::DIFF_W'({qx_i, 2'b00}));
  assign pos_y = signed'(rdsm_pkg::DIFF_W'({qy_i, 2'b00}));
  assign cen_x = rdsm_pkg::DIFF_W'(cx_i);
  assign cen_y = rdsm_pkg::DIFF_W'(cy_i);

  assign dx_d = pos_x - cen_x;
  assign dy_d = pos_y - cen_y;

  assign mx_d = dx_q[rdsm_pkg::DIFF_W-1] ? rdsm_pkg::MAG_W'(-dx_q) : rdsm_pkg::MAG_W'(dx_q);
  assign my_d = dy_q[rdsm_pkg::DIFF_W-1] ? rdsm_pkg::MAG_W'(-dy_q) : rdsm_pkg::MAG_W'(dy_q);

  assign sx_d = mx_q * mx_q;
  assign sy_d = my_q * my_q;

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    mx_q <= mx_d;
    my_q <= my_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
  end

  assign sq_x_o = sx_q;
  assign sq_y_o = sy_q;

endmodule

@@ hdl/rdsm_classify.sv @@
// final stage: distance sums, radius compares, checkerboard and eye xor
module rdsm_classify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic                           chk_i,
  input  logic [rdsm_pkg::SQ_W-1:0]      l_sq_x_i,
  input  logic [rdsm_pkg::SQ_W-1:0]      l_sq_y_i,
  input  logic [rdsm_pkg::SQ_W-1:0]      r_sq_x_i,
  input  logic [rdsm_pkg::SQ_W-1:0]      r_sq_y_i,
  input  rdsm_pkg::cfg_t                 cfg_i,
  output logic                           done_o,
  output logic                           stencil_bit_o
);

  logic [rdsm_pkg::D2_W-1:0] l_d2, r_d2, outer_sq, inner_sq;
  logic                      l_mark, r_mark;
  logic                      done_q, bit_d, bit_q;

  assign l_d2     = rdsm_pkg::D2_W'(l_sq_x_i) + rdsm_pkg::D2_W'(l_sq_y_i);
  assign r_d2     = rdsm_pkg::D2_W'(r_sq_x_i) + rdsm_pkg::D2_W'(r_sq_y_i);
  assign outer_sq = rdsm_pkg::D2_W'(cfg_i.outer_sq);
  assign inner_sq = rdsm_pkg::D2_W'(cfg_i.inner_sq);

  assign l_mark = (l_d2 < outer_sq) && ((l_d2 <= inner_sq) || chk_i);
  assign r_mark = (r_d2 < outer_sq) && ((r_d2 <= inner_sq) || chk_i);
  assign bit_d  = l_mark ^ r_mark;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign done_o        = done_q;
  assign stencil_bit_o = bit_q;

endmodule

@@ hdl/radial_density_stencil_mask.sv @@
// top level of the radial density stencil mask
//
// usage:
//   a pixel transfer is taken at every rising edge with start_i high; busy_o
//   stays low, so a new pixel may be presented on every cycle.
//   pixel_x_i / pixel_y_i select the pixel; its 2x2 quad corner is tested
//   against both eye discs and the xor of the two marks is returned.
//   the result appears on stencil_bit_o with done_o high for exactly one
//   cycle, after the four datapath stages below; results come out in order.
//   throughput is one pixel per cycle, set by the four stage datapath
//   (offset subtract, magnitude, square, sum and compare) with no feedback.
//   the receiver cannot stall, so the pipeline never holds.
//   configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered;
//   the squared radii are registered from them, so writes must be made by
//   the user while no pixel is in flight; the block does not enforce this.
//   reset zeroes the config, valid and done registers; pixels in flight drop.
module radial_density_stencil_mask (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [rdsm_pkg::COORD_BITS-1:0]       pixel_x_i,
  input  logic [rdsm_pkg::COORD_BITS-1:0]       pixel_y_i,
  output logic                                  done_o,
  output logic                                  stencil_bit_o,
  input  logic                                  cfg_we_i,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int PipeDepth = 3;

  rdsm_pkg::cfg_t                      cfg;
  logic [rdsm_pkg::COORD_BITS-1:0]     qx, qy;
  logic [rdsm_pkg::SQ_W-1:0]           l_sq_x, l_sq_y, r_sq_x, r_sq_y;
  logic [PipeDepth-1:0]                valid_d, valid_q;
  logic [PipeDepth-1:0]                chk_d, chk_q;
  logic                                accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign qx = pixel_x_i | rdsm_pkg::COORD_BITS'(1);
  assign qy = pixel_y_i | rdsm_pkg::COORD_BITS'(1);

  rdsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rdsm_eye_pipe u_left (
    .clk_i  (clk_i),
    .qx_i   (qx),
    .qy_i   (qy),
    .cx_i   (cfg.left_cx),
    .cy_i   (cfg.left_cy),
    .sq_x_o (l_sq_x),
    .sq_y_o (l_sq_y)
  );

  rdsm_eye_pipe u_right (
    .clk_i  (clk_i),
    .qx_i   (qx),
    .qy_i   (qy),
    .cx_i   (cfg.right_cx),
    .cy_i   (cfg.right_cy),
    .sq_x_o (r_sq_x),
    .sq_y_o (r_sq_y)
  );

  // checkerboard quads: both coordinates 1 mod 4 or both 3 mod 4
  assign valid_d = {valid_q[PipeDepth-2:0], accept};
  assign chk_d   = {chk_q[PipeDepth-2:0], qx[1] == qy[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
  end

  rdsm_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_q[PipeDepth-1]),
    .chk_i         (chk_q[PipeDepth-1]),
    .l_sq_x_i      (l_sq_x),
    .l_sq_y_i      (l_sq_y),
    .r_sq_x_i      (r_sq_x),
    .r_sq_y_i      (r_sq_y),
    .cfg_i         (cfg),
    .done_o        (done_o),
    .stencil_bit_o (stencil_bit_o)
  );

endmodule

@@ test/tb.sv @@
// self-checking testbench for the radial density stencil mask: directed and random pixels
`timescale 1ns / 1ps

module tb;

  localparam int CW = rdsm_pkg::COORD_BITS;
  localparam logic [rdsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [rdsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 200;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 160;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } pixel_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic                            busy_o;
  logic [CW-1:0]                   pixel_x_i = '0;
  logic [CW-1:0]                   pixel_y_i = '0;
  logic                            done_o;
  logic                            stencil_bit_o;
  logic                            cfg_we_i = 1'b0;
  logic [rdsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [rdsm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  radial_density_stencil_mask DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .done_o        (done_o),
    .stencil_bit_o (stencil_bit_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // geometry as the block should hold it
  logic signed [rdsm_pkg::CEN_W-1:0] geo_lcx = '0;
  logic signed [rdsm_pkg::CEN_W-1:0] geo_lcy = '0;
  logic signed [rdsm_pkg::CEN_W-1:0] geo_rcx = '0;
  logic signed [rdsm_pkg::CEN_W-1:0] geo_rcy = '0;
  logic [rdsm_pkg::RAD_W-1:0]        geo_outer = '0;
  logic [rdsm_pkg::RAD_W-1:0]        geo_inner = '0;

  pixel_t pixel_q[$];
  bit     stencil_q[$];
  pixel_t cur_pixel;
  int     pixels_owed = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     gap_left = 0;
  bit     gapless = 1'b0;
  bit     px_taken = 1'b0;
  bit     want_bit;

  function automatic bit eye_covers(logic [CW-1:0] qx, logic [CW-1:0] qy,
                                    logic signed [rdsm_pkg::CEN_W-1:0] cx,
                                    logic signed [rdsm_pkg::CEN_W-1:0] cy);
    longint dx, dy, d2, outer_sq, inner_sq;
    dx = longint'(qx) * 4 - longint'(cx);
    dy = longint'(qy) * 4 - longint'(cy);
    d2 = dx * dx + dy * dy;
    outer_sq = longint'(geo_outer) * longint'(geo_outer);
    inner_sq = longint'(geo_inner) * longint'(geo_inner);
    if (d2 >= outer_sq) return 1'b0;
    if (d2 <= inner_sq) return 1'b1;
    return (qx[1:0] == 2'b01 && qy[1:0] == 2'b01) ||
           (qx[1:0] == 2'b11 && qy[1:0] == 2'b11);
  endfunction

  function automatic bit stencil_of(logic [CW-1:0] x, logic [CW-1:0] y);
    logic [CW-1:0] qx, qy;
    qx = x | CW'(1);
    qy = y | CW'(1);
    return eye_covers(qx, qy, geo_lcx, geo_lcy) ^ eye_covers(qx, qy, geo_rcx, geo_rcy);
  endfunction

  function automatic logic [CW-1:0] near_coord(int center_q, int span);
    int v;
    v = center_q / 4 + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v[CW-1:0];
  endfunction

  // driver: pixel transfers, changed on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || px_taken)) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        cur_pixel = pixel_q.pop_front();
        pixel_x_i <= cur_pixel.x;
        pixel_y_i <= cur_pixel.y;
        start_i <= 1'b1;
        if (gapless || $urandom_range(0, 2) == 0) gap_left = 0;
        else gap_left = $urandom_range(0, 10);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predicts on each pixel transfer, checks each result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      px_taken = start_i && !busy_o;
      if (px_taken) begin
        stencil_q.push_back(stencil_of(pixel_x_i, pixel_y_i));
        pixels_owed = pixels_owed - 1;
      end
      if (done_o) begin
        if (stencil_q.size() == 0) begin
          $error("stencil_bit: result with no pixel pending, actual %0b", stencil_bit_o);
          mismatches++;
        end else begin
          want_bit = stencil_q.pop_front();
          if (stencil_bit_o !== want_bit) begin
            $error("stencil_bit: expected %0b, actual %0b", want_bit, stencil_bit_o);
            mismatches++;
          end
        end
      end
      if (px_taken || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [rdsm_pkg::CFG_IDX_W-1:0] idx,
                           logic [rdsm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      rdsm_pkg::CFG_LEFT_CX:  geo_lcx = data;
      rdsm_pkg::CFG_LEFT_CY:  geo_lcy = data;
      rdsm_pkg::CFG_RIGHT_CX: geo_rcx = data;
      rdsm_pkg::CFG_RIGHT_CY: geo_rcy = data;
      rdsm_pkg::CFG_OUTER_R:  geo_outer = data;
      rdsm_pkg::CFG_INNER_R:  geo_inner = data;
      default: ;
    endcase
  endtask

  task automatic load_geometry(logic signed [rdsm_pkg::CEN_W-1:0] lcx,
                               logic signed [rdsm_pkg::CEN_W-1:0] lcy,
                               logic signed [rdsm_pkg::CEN_W-1:0] rcx,
                               logic signed [rdsm_pkg::CEN_W-1:0] rcy,
                               logic [rdsm_pkg::RAD_W-1:0] ro,
                               logic [rdsm_pkg::RAD_W-1:0] ri);
    write_reg(rdsm_pkg::CFG_LEFT_CX, lcx);
    write_reg(rdsm_pkg::CFG_LEFT_CY, lcy);
    write_reg(rdsm_pkg::CFG_RIGHT_CX, rcx);
    write_reg(rdsm_pkg::CFG_RIGHT_CY, rcy);
    write_reg(rdsm_pkg::CFG_OUTER_R, ro);
    write_reg(rdsm_pkg::CFG_INNER_R, ri);
    // spare index, must not disturb anything
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
              rdsm_pkg::CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (3) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic queue_pixel(logic [CW-1:0] x, logic [CW-1:0] y);
    pixel_q.push_back('{x: x, y: y});
    pixels_owed = pixels_owed + 1;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (pixels_owed != 0 || stencil_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic random_phase(int kind, int count);
    logic signed [rdsm_pkg::CEN_W-1:0] lcx, lcy, rcx, rcy;
    logic [rdsm_pkg::RAD_W-1:0] ro, ri;
    int ew, eh, span;
    case (kind)
      0: begin
        lcx = rdsm_pkg::CEN_W'($urandom);
        lcy = rdsm_pkg::CEN_W'($urandom);
        rcx = rdsm_pkg::CEN_W'($urandom);
        rcy = rdsm_pkg::CEN_W'($urandom);
        ro = rdsm_pkg::RAD_W'($urandom);
        ri = rdsm_pkg::RAD_W'($urandom);
      end
      1, 2: begin
        ew = $urandom_range(64, 2047);
        eh = $urandom_range(64, 2047);
        lcx = rdsm_pkg::CEN_W'(2 * ew);
        rcx = rdsm_pkg::CEN_W'(6 * ew);
        lcy = rdsm_pkg::CEN_W'(2 * eh);
        rcy = rdsm_pkg::CEN_W'(2 * eh + int'($urandom_range(0, 16)) - 8);
        ro = rdsm_pkg::RAD_W'($urandom_range(ew, 3 * ew));
        ri = (kind == 1) ? rdsm_pkg::RAD_W'($urandom_range(0, ro)) :
                           rdsm_pkg::RAD_W'($urandom_range(ro, 65535));
      end
      3: begin
        lcx = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        lcy = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        rcx = lcx;
        rcy = lcy;
        ro = rdsm_pkg::RAD_W'($urandom_range(0, 4000));
        ri = rdsm_pkg::RAD_W'($urandom_range(0, ro));
      end
      default: begin
        lcx = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        lcy = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        rcx = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        rcy = rdsm_pkg::CEN_W'($urandom_range(0, 16380));
        ro = rdsm_pkg::RAD_W'($urandom_range(0, 64));
        ri = rdsm_pkg::RAD_W'($urandom_range(0, ro));
      end
    endcase
    settle();
    load_geometry(lcx, lcy, rcx, rcy, ro, ri);
    gapless = ($urandom_range(0, 3) == 0);
    span = int'(ro) / 4 + 4;
    if (span > 1200) span = 1200;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_pixel(CW'($urandom), CW'($urandom));
      else if ($urandom_range(0, 1) == 0)
        queue_pixel(near_coord(lcx, span), near_coord(lcy, span));
      else
        queue_pixel(near_coord(rcx, span), near_coord(rcy, span));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero outer radius after reset
    queue_pixel(0, 0);
    queue_pixel('1, '1);
    queue_pixel('1, 0);
    queue_pixel(0, '1);

    // corner exactly on the outer radius is outside
    settle();
    load_geometry(4, 4, -32768, -32768, 8, 4);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(2, 0);
    queue_pixel(0, 2);

    // ring: checkerboard quads only, corner on the inner radius is full density
    settle();
    load_geometry(4, 4, -32768, -32768, 12, 7);
    queue_pixel(0, 0);
    queue_pixel(2, 0);
    queue_pixel(2, 2);
    settle();
    load_geometry(4, 4, -32768, -32768, 12, 8);
    queue_pixel(2, 0);
    queue_pixel(0, 3);

    // both eyes mark the same quad, then inner radius above outer
    settle();
    load_geometry(4, 4, 4, 4, 12, 8);
    queue_pixel(0, 0);
    settle();
    load_geometry(4, 4, -32768, -32768, 12, 16'hFFFF);
    queue_pixel(2, 2);

    // register extremes
    settle();
    load_geometry(-32768, 32767, 32767, -32768, 16'hFFFF, 0);
    queue_pixel(0, 0);
    queue_pixel('1, '1);
    queue_pixel('1, 0);
    queue_pixel(0, '1);
    queue_pixel(1, 2);

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p % 5, PIXELS_PER_PHASE);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && stencil_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ radial_density_stencil_mask.f @@
hdl/rdsm_pkg.sv
hdl/rdsm_cfg_regs.sv
hdl/rdsm_eye_pipe.sv
hdl/rdsm_classify.sv
hdl/radial_density_stencil_mask.sv
test/tb.sv
